### sv/arl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arl_pkg;

  // fixed field widths
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

### sv/array_list_append_read_remove.sv
`timescale 1ns / 1ps
`default_nettype none

// bounded ordered list of signed words held in one synchronous ram
//
// request channel: in_mode/in_index/in_value are taken at a rising edge
// where start is high and busy is low. modes: append a word at the end,
// read the word at an index, remove the word at an index (later words move
// down one place). the spare mode code is answered with ok and no change.
// result channel: every request gives exactly one result, shown for one
// cycle while out_valid is high: out_data, out_status and out_count (the
// element count after the request). the receiver cannot hold results off.
// latency: append, read and out-of-range or last-element remove answer in
// the cycle after acceptance and leave busy low, so one request per cycle.
// a remove of an inner element walks the ram with a one-deep read/write
// pipeline: each cycle writes one word one place down and reads the next.
// it holds the block from the accepting cycle until the last word is written,
// with busy high while the walk runs; the ram's single read port and single
// write port set the remove time.
// the ram needs no clearing: reads only reach indices below the count,
// which always hold written words. reset clears the count, the control
// state and the result registers only.

module array_list_append_read_remove
  import arl_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire  [MODE_W-1:0]          in_mode,
  input  wire  [IDX_W-1:0]           in_index,
  input  wire  signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_data,
  output logic [STATUS_W-1:0]        out_status,
  output logic [COUNT_W-1:0]         out_count
);

  // address and count widths follow the capacity
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // common width for comparing an index against the count
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  // list storage: one write port, one registered read port
  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rd_q;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;

  // control and result registers
  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         wr_r, wr_nxt;        // destination of the next shift write
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;
  logic                  out_rd_r, out_rd_nxt;    // result data comes from the ram
  logic                  out_neg_r, out_neg_nxt;  // result data is all ones

  logic                  accept;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         cnt_x;
  logic                  idx_ok;
  logic                  has_tail;
  logic                  is_full;
  logic                  shift_done;

  assign accept   = start && (state_r == ST_IDLE);
  assign idx_x    = XW'(in_index);
  assign cnt_x    = XW'(count_r);
  assign idx_ok   = idx_x < cnt_x;
  // some element sits after the one removed (no overflow once idx_ok holds)
  assign has_tail = idx_ok && ((idx_x + XW'(1)) < cnt_x);
  assign is_full  = count_r == CW'(CAPACITY);
  // last pending word is written this cycle
  assign shift_done = ((CW + 1)'(wr_r) + (CW + 1)'(2)) >= (CW + 1)'(count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    wr_nxt         = wr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_count_nxt  = count_r;
    out_rd_nxt     = 1'b0;
    out_neg_nxt    = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = VALUE_WIDTH'(in_value);
    mem_re         = 1'b0;
    mem_raddr      = idx_x[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_mode)
            MODE_APPEND: begin
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we        = 1'b1;
                count_nxt     = count_r + CW'(1);
                out_count_nxt = count_r + CW'(1);
              end
            end
            MODE_READ: begin
              if (idx_ok) begin
                mem_re     = 1'b1;
                out_rd_nxt = 1'b1;
              end else begin
                out_status_nxt = STAT_RANGE;
                out_neg_nxt    = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (!idx_ok) begin
                out_status_nxt = STAT_RANGE;
              end else if (has_tail) begin
                // start the walk: fetch the word after the removed one
                mem_re        = 1'b1;
                mem_raddr     = AW'(idx_x + XW'(1));
                wr_nxt        = idx_x[AW-1:0];
                state_nxt     = ST_SHIFT;
                out_valid_nxt = 1'b0;
              end else begin
                // removing the last element needs no move
                count_nxt     = count_r - CW'(1);
                out_count_nxt = count_r - CW'(1);
              end
            end
            default: begin
              // spare code: no change, ok status
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // word fetched last cycle goes one place down
        mem_we    = 1'b1;
        mem_waddr = wr_r;
        mem_wdata = rd_q;
        if (shift_done) begin
          count_nxt     = count_r - CW'(1);
          out_count_nxt = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wr_r + AW'(2);
          wr_nxt    = wr_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      wr_r         <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STAT_OK;
      out_count_r  <= '0;
      out_rd_r     <= 1'b0;
      out_neg_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      wr_r         <= wr_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
      out_rd_r     <= out_rd_nxt;
      out_neg_r    <= out_neg_nxt;
    end
  end

  // ram: a read never meets a write to the same entry in one cycle, since
  // the walk writes behind its read pointer and no request enters meanwhile
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign busy       = (state_r == ST_SHIFT);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = COUNT_W'(out_count_r);

  always_comb begin
    if (out_rd_r) begin
      out_data = DATA_W'(rd_q);
    end else if (out_neg_r) begin
      out_data = '1;
    end else begin
      out_data = '0;
    end
  end

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // each result comes from an accepted request or the end of a walk
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(accept) || $past(state_r == ST_SHIFT)))
    else $error("result without a request");

  // the walk only writes below the last element
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> ((CW + 1)'(wr_r) + (CW + 1)'(1)) < (CW + 1)'(count_r))
    else $error("shift write beyond the list");

  // a refused append reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_FULL)) |-> (out_count_r == CW'(CAPACITY)))
    else $error("full status with room left");

endmodule

`default_nettype wire
